FILE: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int SCROLL_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int PH_W     = $clog2(TAB_STOP);

    localparam logic [7:0]  CH_BS      = 8'd8;
    localparam logic [7:0]  CH_TAB     = 8'd9;
    localparam logic [7:0]  CH_NL      = 8'd10;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  RESET_ATTR = 8'h07;
    localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [15:0] cell_value;
        logic        scrolled;
    } rsp_t;

    // cursor update computed for one put item
    typedef struct packed {
        logic [6:0]      col;
        logic [4:0]      row;
        logic [PH_W-1:0] phase;
        logic            wr_en;
        logic [6:0]      wr_col;
        logic [15:0]     wr_data;
        logic            scroll;
    } cur_upd_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] row,
                                                    input logic [6:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
        return a;
    endfunction

endpackage

FILE: rtl/text_console_writer.sv
// put: result in the cycle after start unless the put scrolls; if not, the next item is accepted right away
// read: the frame store read port registers the cell, then S_READ registers the result
// clear: one store write per cell, then the result
// scroll: one cell copy per cycle then the bottom line, then the result
// reset: cursor homed, attribute 0x07, then a pass over every cell fills the store
// results are one-cycle strobes; the receiver cannot stall them
module text_console_writer
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_BLANK
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] cp_addr_reg;
    logic              cp_pend_reg;
    logic [6:0]        col_reg;
    logic [4:0]        row_reg;
    logic [PH_W-1:0]   phase_reg;
    logic [7:0]        attr_reg;
    logic              rd_ok_reg;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic              accept;
    logic              rd_in_range;
    logic              ptr_last;
    logic [15:0]       blank;
    cur_upd_t          upd;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign done        = done_reg;
    assign rsp         = rsp_reg;
    assign blank       = {attr_reg, CH_SPACE};
    assign ptr_last    = (ptr_reg == ADDR_W'(CELLS - 1));
    assign rd_in_range = (32'(cmd.read_row) < 32'(ROWS)) && (32'(cmd.read_col) < 32'(COLUMNS));

    tcw_cursor u_cursor (
        .col       (col_reg),
        .row       (row_reg),
        .phase     (phase_reg),
        .char_code (cmd.char_code),
        .attr      (attr_reg),
        .upd       (upd)
    );

    tcw_ram #(
        .DEPTH (CELLS),
        .WIDTH (16)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = blank;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg;
        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
            end
            S_IDLE:
            begin
                if (accept && cmd.func == FUNC_PUT)
                begin
                    ram_we    = upd.wr_en;
                    ram_waddr = cell_addr(row_reg, upd.wr_col);
                    ram_wdata = upd.wr_data;
                end
                if (accept && cmd.func == FUNC_READ)
                begin
                    ram_re    = rd_in_range;
                    ram_raddr = cell_addr(cmd.read_row, cmd.read_col);
                end
            end
            S_READ:
            begin
            end
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_SCROLL:
            begin
                // read one line below, write back what the last read returned
                ram_re    = (ptr_reg < ADDR_W'(SCROLL_N));
                ram_raddr = ptr_reg + ADDR_W'(COLUMNS);
                ram_we    = cp_pend_reg;
                ram_waddr = cp_addr_reg;
                ram_wdata = ram_rdata;
            end
            S_BLANK:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            ptr_reg     <= '0;
            cp_addr_reg <= '0;
            cp_pend_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            attr_reg    <= RESET_ATTR;
            rd_ok_reg   <= 1'b0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end

            unique case (state_reg)
                S_INIT:
                begin
                    ptr_reg <= ptr_reg + ADDR_W'(1);
                    if (ptr_last)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.func)
                            FUNC_PUT:
                            begin
                                col_reg   <= upd.col;
                                row_reg   <= upd.row;
                                phase_reg <= upd.phase;
                                if (upd.scroll)
                                begin
                                    ptr_reg     <= '0;
                                    cp_pend_reg <= 1'b0;
                                    state_reg   <= S_SCROLL;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= '{upd.col, upd.row, 16'd0, 1'b0};
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                col_reg   <= '0;
                                row_reg   <= '0;
                                phase_reg <= '0;
                                ptr_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            FUNC_READ:
                            begin
                                rd_ok_reg <= rd_in_range;
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                                rsp_reg  <= '{col_reg, row_reg, 16'd0, 1'b0};
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    done_reg  <= 1'b1;
                    rsp_reg   <= '{col_reg, row_reg, rd_ok_reg ? ram_rdata : 16'd0, 1'b0};
                    state_reg <= S_IDLE;
                end
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + ADDR_W'(1);
                    if (ptr_last)
                    begin
                        ptr_reg   <= '0;
                        done_reg  <= 1'b1;
                        rsp_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_SCROLL:
                begin
                    cp_addr_reg <= ptr_reg;
                    if (ptr_reg < ADDR_W'(SCROLL_N))
                    begin
                        cp_pend_reg <= 1'b1;
                        ptr_reg     <= ptr_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        // last copy drains this cycle, ptr already at bottom line
                        cp_pend_reg <= 1'b0;
                        state_reg   <= S_BLANK;
                    end
                end
                S_BLANK:
                begin
                    ptr_reg <= ptr_reg + ADDR_W'(1);
                    if (ptr_last)
                    begin
                        ptr_reg   <= '0;
                        done_reg  <= 1'b1;
                        rsp_reg   <= '{col_reg, row_reg, 16'd0, 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/tcw_ram.sv
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/tcw_cursor.sv
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic [6:0]      col,
    input  logic [4:0]      row,
    input  logic [PH_W-1:0] phase,
    input  logic [7:0]      char_code,
    input  logic [7:0]      attr,
    output cur_upd_t        upd
);

    logic [7:0]      nx;
    logic [5:0]      ny;
    logic [PH_W-1:0] nph;

    always_comb
    begin
        nx           = {1'b0, col};
        ny           = {1'b0, row};
        nph          = phase;
        upd.wr_en    = 1'b0;
        upd.wr_col   = col;
        upd.wr_data  = {attr, char_code};

        if (char_code == CH_NL)
        begin
            nx  = '0;
            ny  = ny + 6'd1;
            nph = '0;
        end
        else if (char_code == CH_TAB)
        begin
            // phase tracks col mod tab stop
            nx  = {1'b0, col} + 8'(TAB_STOP) - 8'(phase);
            nph = '0;
        end
        else if (char_code == CH_BS)
        begin
            if (col != '0)
            begin
                nx          = {1'b0, col} - 8'd1;
                nph         = (phase == '0) ? PH_W'(TAB_STOP - 1) : phase - PH_W'(1);
                upd.wr_en   = 1'b1;
                upd.wr_col  = col - 7'd1;
                upd.wr_data = {attr, CH_SPACE};
            end
        end
        else
        begin
            nx        = {1'b0, col} + 8'd1;
            nph       = (phase == PH_W'(TAB_STOP - 1)) ? '0 : phase + PH_W'(1);
            upd.wr_en = 1'b1;
        end

        if (nx >= 8'(COLUMNS))
        begin
            nx  = '0;
            ny  = ny + 6'd1;
            nph = '0;
        end

        upd.scroll = 1'b0;
        if (ny >= 6'(ROWS))
        begin
            ny         = 6'(ROWS - 1);
            upd.scroll = 1'b1;
        end

        upd.col   = nx[6:0];
        upd.row   = ny[4:0];
        upd.phase = nph;
    end

endmodule

FILE: bench/text_console_writer_tb.sv
module text_console_writer_tb
    import tcw_pkg::*;
();

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int PHASE_ITEMS = 85;
    localparam int CMD_W       = $bits(cmd_t);

    // tracks the console state and the replies still owed by the block
    class console_scoreboard;
        logic [15:0] frame [CELLS];
        int          cur_col;
        int          cur_row;
        logic [7:0]  attr;
        rsp_t        console_replies [$];
        int          errors;
        int          shown;
        int          checked;
        int          scrolls;
        int          clears;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                frame[i] = RESET_CELL;
            end
            cur_col = 0;
            cur_row = 0;
            attr    = RESET_ATTR;
            errors  = 0;
            shown   = 0;
            checked = 0;
            scrolls = 0;
            clears  = 0;
        endfunction

        function void set_attr(logic [7:0] v);
            attr = v;
        endfunction

        function int pending();
            return console_replies.size();
        endfunction

        function void apply_command(cmd_t c);
            rsp_t r;
            r = '0;
            case (func_t'(c.func))
                FUNC_PUT:
                begin
                    if (c.char_code == CH_NL)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    else if (c.char_code == CH_TAB)
                    begin
                        cur_col = cur_col + TAB_STOP - cur_col % TAB_STOP;
                    end
                    else if (c.char_code == CH_BS)
                    begin
                        if (cur_col > 0)
                        begin
                            cur_col--;
                            frame[cur_row * COLUMNS + cur_col] = {attr, CH_SPACE};
                        end
                    end
                    else
                    begin
                        frame[cur_row * COLUMNS + cur_col] = {attr, c.char_code};
                        cur_col++;
                    end
                    if (cur_col >= COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    // past the bottom line: move everything up and blank the last line
                    if (cur_row >= ROWS)
                    begin
                        cur_row = ROWS - 1;
                        for (int i = 0; i < SCROLL_N; i++)
                        begin
                            frame[i] = frame[i + COLUMNS];
                        end
                        for (int i = SCROLL_N; i < CELLS; i++)
                        begin
                            frame[i] = {attr, CH_SPACE};
                        end
                        r.scrolled = 1'b1;
                        scrolls++;
                    end
                end
                FUNC_CLEAR:
                begin
                    for (int i = 0; i < CELLS; i++)
                    begin
                        frame[i] = {attr, CH_SPACE};
                    end
                    cur_col = 0;
                    cur_row = 0;
                    clears++;
                end
                FUNC_READ:
                begin
                    // out-of-range cells read as zero
                    if (c.read_row < ROWS && c.read_col < COLUMNS)
                    begin
                        r.cell_value = frame[int'(c.read_row) * COLUMNS + int'(c.read_col)];
                    end
                end
                default:
                begin
                end
            endcase
            r.cursor_col = 7'(cur_col);
            r.cursor_row = 5'(cur_row);
            console_replies.push_back(r);
        endfunction

        function void compare_reply(rsp_t got);
            rsp_t want;
            if (console_replies.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result: col %0d row %0d cell %h scrolled %b",
                             got.cursor_col, got.cursor_row, got.cell_value, got.scrolled);
                end
                return;
            end
            want = console_replies.pop_front();
            checked++;
            if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
                got.cell_value !== want.cell_value || got.scrolled !== want.scrolled)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("mismatch on result %0d: expected col %0d row %0d cell %h scrolled %b",
                             checked, want.cursor_col, want.cursor_row, want.cell_value,
                             want.scrolled);
                    $display("                       got col %0d row %0d cell %h scrolled %b",
                             got.cursor_col, got.cursor_row, got.cell_value, got.scrolled);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    cmd_t       cmd;
    logic       done;
    rsp_t       rsp;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    console_scoreboard board;
    int cycle_count = 0;
    int items_sent  = 0;
    int attr_writes = 0;
    bit quiet_phase = 1'b0;

    text_console_writer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.compare_reply(rsp);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timed out after %0d cycles", cycle_count);
        $display("** text_console_writer: FAILED **");
        $finish;
    end

    function automatic cmd_t make_put(logic [7:0] ch);
        cmd_t c;
        c           = cmd_t'(CMD_W'($urandom));
        c.func      = FUNC_PUT;
        c.char_code = ch;
        return c;
    endfunction

    function automatic cmd_t make_read(int row, int col);
        cmd_t c;
        c          = cmd_t'(CMD_W'($urandom));
        c.func     = FUNC_READ;
        c.read_row = 5'(row);
        c.read_col = 7'(col);
        return c;
    endfunction

    // leaves start high after the item is taken so the next one can follow at once
    task automatic issue(cmd_t c);
        if (!quiet_phase && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        board.apply_command(c);
        items_sent++;
    endtask

    task automatic set_attribute(logic [7:0] v);
        start <= 1'b0;
        do @(posedge clk); while (board.pending() != 0 || busy);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_attr(v);
        attr_writes++;
    endtask

    initial
    begin
        cmd_t       c;
        int         pick;
        int         sub;
        int         n;
        int         phase_count;
        logic [7:0] ch;

        board       = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, out-of-range reads, byte extremes, control codes
        issue(make_read(0, 0));
        issue(make_read(ROWS - 1, COLUMNS - 1));
        issue(make_read(31, 127));
        issue(make_read(0, COLUMNS));
        issue(make_read(ROWS, 0));
        issue(make_put(CH_BS));
        issue(make_put(8'h00));
        issue(make_put(8'hFF));
        issue(make_put(8'h41));
        issue(make_put(CH_BS));
        issue(make_read(0, 2));
        issue(make_read(0, 1));
        issue(make_put(CH_TAB));
        c = '1;
        issue(c);
        issue(make_put(CH_NL));
        issue(make_read(0, 8));
        c      = cmd_t'(CMD_W'($urandom));
        c.func = FUNC_CLEAR;
        issue(c);
        issue(make_read(0, 1));

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_attribute(8'hFF);
                1:       set_attribute(8'h00);
                4:       set_attribute(RESET_ATTR);
                default: set_attribute(8'($urandom));
            endcase
            quiet_phase = (phase == 3);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                begin
                    // run of line feeds and tabs to reach the bottom and scroll
                    n = $urandom_range(10, 30);
                    repeat (n)
                    begin
                        issue(make_put($urandom_range(99) < 80 ? CH_NL : CH_TAB));
                    end
                    phase_count += n;
                end
                else if (pick < 5)
                begin
                    // long line of printable text to wrap at the last column
                    n = $urandom_range(70, 100);
                    repeat (n)
                    begin
                        issue(make_put(8'($urandom_range(32, 126))));
                    end
                    phase_count += n;
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 73)
                    begin
                        ch  = 8'($urandom);
                        sub = $urandom_range(99);
                        if (sub < 10)
                            ch = CH_NL;
                        else if (sub < 16)
                            ch = CH_TAB;
                        else if (sub < 22)
                            ch = CH_BS;
                        issue(make_put(ch));
                    end
                    else if (pick < 94)
                    begin
                        sub = $urandom_range(99);
                        if (sub < 50)
                            issue(make_read($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1)));
                        else if (sub < 80)
                            issue(make_read(board.cur_row, $urandom_range(COLUMNS - 1)));
                        else
                            issue(make_read($urandom_range(31), $urandom_range(127)));
                    end
                    else if (pick < 99)
                    begin
                        c      = cmd_t'(CMD_W'($urandom));
                        c.func = FUNC_NOP;
                        issue(c);
                    end
                    else
                    begin
                        c      = cmd_t'(CMD_W'($urandom));
                        c.func = FUNC_CLEAR;
                        issue(c);
                    end
                    phase_count++;
                end
            end
        end

        start <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d items under %0d attribute settings, %0d results checked",
                 items_sent, attr_writes, board.checked);
        $display("saw %0d scrolls and %0d screen clears, %0d mismatches",
                 board.scrolls, board.clears, board.errors);
        if (board.errors == 0)
            $display("** text_console_writer: PASSED **");
        else
            $display("** text_console_writer: FAILED **");
        $finish;
    end

endmodule
